@@ design/rsd_pkg.sv @@
// ----------------------------------------------------------------------------
// Readout stream deframer package
// Shared types, codes and record builders for the deframer front and back.
// ----------------------------------------------------------------------------
package rsd_pkg;

   typedef enum logic [13:0] {
      ST_WAIT_START  = 14'h0001,
      ST_WAIT_BOARD  = 14'h0002,
      ST_WCNT        = 14'h0004,
      ST_EVNUM       = 14'h0008,
      ST_FRNUM       = 14'h0010,
      ST_CSUM        = 14'h0020,
      ST_SNUM        = 14'h0040,
      ST_WAIT_CHAN   = 14'h0080,
      ST_WAIT_RSTART = 14'h0100,
      ST_WAIT_REND   = 14'h0200,
      ST_HDR_L       = 14'h0400,
      ST_RESYNC      = 14'h0800,
      ST_EV_END      = 14'h1000,
      ST_END_TAG     = 14'h2000
   } parse_state_type;

   localparam logic [2:0] KIND_SAMPLE    = 3'd0;
   localparam logic [2:0] KIND_CHAN_END  = 3'd1;
   localparam logic [2:0] KIND_BOARD_HDR = 3'd2;
   localparam logic [2:0] KIND_FIELD     = 3'd3;
   localparam logic [2:0] KIND_TOTALS    = 3'd4;
   localparam logic [2:0] KIND_INVALID   = 3'd5;
   localparam logic [2:0] KIND_EVENT_END = 3'd6;

   localparam logic [1:0] REG_START_PAT = 2'd0;
   localparam logic [1:0] REG_END_PAT   = 2'd1;
   localparam logic [1:0] REG_BOARD_PAT = 2'd2;
   localparam logic [1:0] REG_HUFF_TAB  = 2'd3;

   typedef enum logic [1:0] {
      SOP_NONE  = 2'd0,
      SOP_PLAIN = 2'd1,
      SOP_LAST  = 2'd2,
      SOP_HUFF  = 2'd3
   } sop_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [4:0]  slot;
      logic [5:0]  chan_num;
      logic [5:0]  chan_frame;
      logic [31:0] value_a;
      logic [31:0] value_b;
      logic [2:0]  flags;
   } rec_type;

   typedef struct packed {
      logic [1:0]  nrec;
      rec_type     rec0;
      rec_type     rec1;
      logic        clr_sc;
      sop_type     sop;
      logic [14:0] sdata;
      logic [4:0]  slot;
      logic [11:0] chan_info;
      logic [15:0] region_idx;
      logic [13:0] region_time;
   } cmd_type;

   function automatic rec_type rec_blank(logic [2:0] kind, logic [4:0] slot);
      rec_type r;
      r = '0;
      r.kind = kind;
      r.slot = slot;
      return r;
   endfunction

   function automatic rec_type rec_chan_end(logic [4:0] slot, logic [11:0] ci,
                                            logic [15:0] sm, logic [15:0] em);
      rec_type r;
      r = rec_blank(KIND_CHAN_END, slot);
      r.chan_num = ci[5:0];
      r.chan_frame = ci[11:6];
      r.value_a = {16'h0, sm};
      r.value_b = {16'h0, em};
      return r;
   endfunction

   function automatic rec_type rec_totals(logic [4:0] slot, logic [31:0] wc,
                                          logic [31:0] cs);
      rec_type r;
      r = rec_blank(KIND_TOTALS, slot);
      r.value_a = wc;
      r.value_b = cs;
      return r;
   endfunction

   function automatic rec_type rec_event_end(logic [31:0] ec, logic [1:0] fl);
      rec_type r;
      r = rec_blank(KIND_EVENT_END, 5'd0);
      r.value_a = ec;
      r.flags = {1'b0, fl};
      return r;
   endfunction

   function automatic logic slot_ok(logic [4:0] s);
      return (s > 5'd2) && (s < 5'd19);
   endfunction

endpackage

@@ design/rsd_req_if.sv @@
// ----------------------------------------------------------------------------
// Deframer request channel
// Valid/ready channel that carries one 16-bit stream word per request.
// ----------------------------------------------------------------------------
interface rsd_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] stream_word;

   modport source (output valid, output stream_word, input ready);
   modport sink (input valid, input stream_word, output ready);
endinterface

@@ design/rsd_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Deframer result channel
// Valid/ready channel that carries one decoded record per transfer.
// ----------------------------------------------------------------------------
interface rsd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [4:0]  board_slot;
   logic [5:0]  channel_number;
   logic [5:0]  channel_frame;
   logic [15:0] region_index;
   logic [15:0] sample_time;
   logic [15:0] adc_value;
   logic [31:0] value_a;
   logic [31:0] value_b;
   logic [2:0]  flag_bits;
   logic        last;

   modport source (output valid, output kind, output board_slot, output channel_number,
                   output channel_frame, output region_index, output sample_time,
                   output adc_value, output value_a, output value_b, output flag_bits,
                   output last, input ready);
   modport sink (input valid, input kind, input board_slot, input channel_number,
                 input channel_frame, input region_index, input sample_time,
                 input adc_value, input value_a, input value_b, input flag_bits,
                 input last, output ready);
endinterface

@@ design/readout_stream_deframer.sv @@
// ----------------------------------------------------------------------------
// Readout stream deframer
// Parses a 16-bit detector readout stream into sample and bookkeeping records.
// ----------------------------------------------------------------------------
// The request channel takes one 16-bit stream word per request, low half of
// each 32-bit word first. The result channel delivers records (samples,
// channel ends, board headers and fields, board totals, board invalid and
// event ends); last marks the final record caused by a request.
// The parser front takes a request every cycle while its four-entry command
// queue has room. The back end drains one record per cycle while the
// receiver takes them; a request causes up to fifteen records for a zero-run
// word. The first record of a request passes through the command queue, the
// back end's command register and the output register before it appears.
// Registers are written over the APB-style port at byte addresses 0, 8, 16, 24;
// the user must write them only while the block is idle, which the block does
// not enforce. Reset clears the parser, queue, output valid and registers.
// When the receiver stalls, the output register holds its record, the back
// end waits, the queue fills, and then the request channel deasserts ready.
// ----------------------------------------------------------------------------
module readout_stream_deframer (
   input  logic        clock,
   input  logic        reset,
   rsd_req_if.sink     req_bus,
   rsd_rsp_if.source   rsp_bus,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   import rsd_pkg::*;

   logic [31:0] start_pat_ff;
   logic [15:0] end_pat_ff, board_pat_ff;
   logic [59:0] huff_tab_ff;
   logic        wr_en, accept, cmd_push, cmd_pop, q_full, q_avail;
   cmd_type     cmd_in, cmd_head;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite;
   assign req_bus.ready = !q_full;
   assign accept = req_bus.valid && !q_full;

   always_comb begin
      unique case (csr_paddr[4:3])
         REG_START_PAT: csr_prdata = {32'h0, start_pat_ff};
         REG_END_PAT:   csr_prdata = {48'h0, end_pat_ff};
         REG_BOARD_PAT: csr_prdata = {48'h0, board_pat_ff};
         default:       csr_prdata = {4'h0, huff_tab_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_pat_ff <= '0;
         end_pat_ff <= '0;
         board_pat_ff <= '0;
         huff_tab_ff <= '0;
      end else if (wr_en) begin
         unique case (csr_paddr[4:3])
            REG_START_PAT: start_pat_ff <= csr_pwdata[31:0];
            REG_END_PAT:   end_pat_ff <= csr_pwdata[15:0];
            REG_BOARD_PAT: board_pat_ff <= csr_pwdata[15:0];
            default:       huff_tab_ff <= csr_pwdata[59:0];
         endcase
      end
   end

   rsd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .word      (req_bus.stream_word),
      .start_pat (start_pat_ff),
      .end_pat   (end_pat_ff),
      .board_pat (board_pat_ff),
      .cmd_push  (cmd_push),
      .cmd       (cmd_in)
   );

   rsd_cmd_fifo u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .pop       (cmd_pop),
      .pop_data  (cmd_head),
      .full      (q_full),
      .not_empty (q_avail)
   );

   rsd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .huff_tab  (huff_tab_ff),
      .cmd_avail (q_avail),
      .cmd_head  (cmd_head),
      .cmd_pop   (cmd_pop),
      .rsp_bus   (rsp_bus)
   );
endmodule

@@ design/rsd_front.sv @@
// ----------------------------------------------------------------------------
// Deframer parser front
// Pairs half words, runs the stream parser and issues at most one command per request.
// ----------------------------------------------------------------------------
module rsd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [15:0]       word,
   input  logic [31:0]       start_pat,
   input  logic [15:0]       end_pat,
   input  logic [15:0]       board_pat,
   output logic              cmd_push,
   output rsd_pkg::cmd_type  cmd
);
   import rsd_pkg::*;

   parse_state_type state_ff, state_in;
   logic        half_ff, half_in;
   logic [15:0] low_ff, low_in;
   logic [4:0]  slot_ff, slot_in;
   logic [31:0] wc_ff, wc_in, cs_ff, cs_in, ec_ff, ec_in;
   logic [15:0] rc_ff, rc_in, sm_ff, sm_in, em_ff, em_in;
   logic [13:0] rt_ff, rt_in;
   logic        armed_ff, armed_in;
   logic [1:0]  fl_ff, fl_in;
   logic [11:0] ci_ff, ci_in;

   rec_type     recs [2];
   logic [1:0]  n;
   logic        clr;
   sop_type     sop;
   logic [31:0] w32;
   logic [3:0]  hi4;
   logic [4:0]  s;

   always_comb begin
      state_in = state_ff; half_in = half_ff; low_in = low_ff; slot_in = slot_ff;
      wc_in = wc_ff; cs_in = cs_ff; ec_in = ec_ff; rc_in = rc_ff; sm_in = sm_ff;
      em_in = em_ff; rt_in = rt_ff; armed_in = armed_ff; fl_in = fl_ff; ci_in = ci_ff;
      recs[0] = '0; recs[1] = '0; n = 2'd0; clr = 1'b0; sop = SOP_NONE;
      w32 = {word, low_ff};
      hi4 = word[15:12];
      s = '0;
      if (accept) begin
         if (|state_ff[6:0]) begin
            if (!half_ff) begin
               low_in = word;
               half_in = 1'b1;
            end else begin
               half_in = 1'b0;
               unique case (state_ff)
                  ST_WAIT_START: begin
                     if (w32 == start_pat) begin
                        if (ec_ff != 32'd0) begin
                           recs[0] = rec_event_end(ec_ff, fl_ff);
                           n = 2'd1;
                        end
                        ec_in = ec_ff + 32'd1;
                        fl_in = 2'd3;
                        state_in = ST_WAIT_BOARD;
                     end else if (w32 == {16'hFFFF, end_pat}) begin
                        state_in = ST_END_TAG;
                     end
                  end
                  ST_WAIT_BOARD: begin
                     if (w32 == {end_pat, 16'h0000}) begin
                        clr = 1'b1;
                        fl_in = fl_ff & 2'd2;
                        state_in = ST_WAIT_START;
                     end else if (w32[15:0] == board_pat && w32[31:28] == 4'hF) begin
                        s = w32[20:16];
                        slot_in = s;
                        if (slot_ok(s)) begin
                           fl_in = fl_ff & 2'd1;
                           recs[0] = rec_blank(KIND_BOARD_HDR, s);
                           recs[0].value_a = {28'h0, w32[24:21]};
                           recs[0].flags = w32[27:25];
                           n = 2'd1;
                           wc_in = '0;
                           cs_in = '0;
                           state_in = ST_WCNT;
                        end else begin
                           state_in = ST_RESYNC;
                        end
                     end else begin
                        state_in = ST_RESYNC;
                     end
                  end
                  default: begin
                     if (w32[31:28] == 4'hF && w32[15:12] == 4'hF) begin
                        recs[0] = rec_blank(KIND_FIELD, slot_ff);
                        recs[0].value_b = {8'h0, w32[11:0], w32[27:16]};
                        n = 2'd1;
                        priority case (state_ff)
                           ST_WCNT: begin
                              recs[0].value_a = 32'd0;
                              state_in = ST_EVNUM;
                           end
                           ST_EVNUM: begin
                              recs[0].value_a = 32'd1;
                              state_in = ST_FRNUM;
                           end
                           ST_FRNUM: begin
                              recs[0].value_a = 32'd2;
                              state_in = ST_CSUM;
                           end
                           ST_CSUM: begin
                              recs[0].value_a = 32'd3;
                              state_in = ST_SNUM;
                           end
                           default: begin
                              n = 2'd0;
                              state_in = ST_WAIT_CHAN;
                           end
                        endcase
                     end else begin
                        recs[0] = rec_blank(KIND_INVALID, slot_ff);
                        n = 2'd1;
                        state_in = ST_RESYNC;
                     end
                  end
               endcase
            end
         end else begin
            half_in = 1'b0;
            unique case (state_ff)
               ST_END_TAG: begin
                  if (word == 16'hFFFF) begin
                     ec_in = ec_ff + 32'd1;
                     fl_in = 2'd3;
                     state_in = ST_WAIT_BOARD;
                  end else begin
                     state_in = ST_RESYNC;
                  end
               end
               ST_WAIT_CHAN: begin
                  if (word == 16'h0) begin
                     recs[0] = rec_totals(slot_ff, wc_ff, cs_ff);
                     n = 2'd1;
                     state_in = ST_EV_END;
                  end else if (word == board_pat) begin
                     state_in = ST_HDR_L;
                  end else begin
                     wc_in = wc_ff + 32'd1;
                     cs_in = cs_ff + {16'h0, word};
                     if (hi4 == 4'h1) begin
                        ci_in = word[11:0];
                        rc_in = '0; armed_in = 1'b1; sm_in = '0; em_in = '0;
                        state_in = ST_WAIT_RSTART;
                     end
                  end
               end
               ST_WAIT_RSTART, ST_WAIT_REND: begin
                  if (state_ff == ST_WAIT_REND && (word == 16'h0 || word == board_pat ||
                      hi4 == 4'h1 || word[15:14] == 2'b01)) begin
                     em_in = em_ff + 16'd1;
                  end
                  if (word == 16'h0) begin
                     recs[0] = rec_chan_end(slot_ff, ci_ff, sm_ff, em_in);
                     recs[1] = rec_totals(slot_ff, wc_ff, cs_ff);
                     n = 2'd2;
                     state_in = ST_EV_END;
                  end else if (word == board_pat) begin
                     recs[0] = rec_chan_end(slot_ff, ci_ff, sm_ff, em_in);
                     n = 2'd1;
                     state_in = ST_HDR_L;
                  end else begin
                     wc_in = wc_ff + 32'd1;
                     cs_in = cs_ff + {16'h0, word};
                     if (hi4 == 4'h1) begin
                        recs[0] = rec_chan_end(slot_ff, ci_ff, sm_ff, em_in);
                        n = 2'd1;
                        ci_in = word[11:0];
                        rc_in = '0; armed_in = 1'b1; sm_in = '0; em_in = '0;
                        state_in = ST_WAIT_RSTART;
                     end else if (word[15:14] == 2'b01) begin
                        rt_in = word[13:0];
                        rc_in = rc_ff + 16'd1;
                        clr = 1'b1;
                        armed_in = 1'b1;
                        state_in = ST_WAIT_REND;
                     end else if (state_ff == ST_WAIT_RSTART) begin
                        if (armed_ff) begin
                           sm_in = sm_ff + 16'd1;
                           armed_in = 1'b0;
                        end
                     end else if (hi4 == 4'h3) begin
                        sop = SOP_LAST;
                        state_in = ST_WAIT_RSTART;
                     end else if (hi4 == 4'h2) begin
                        sop = SOP_PLAIN;
                     end else if (word[15]) begin
                        sop = SOP_HUFF;
                     end
                  end
               end
               ST_HDR_L: begin
                  if (slot_ok(slot_ff)) begin
                     recs[0] = rec_totals(slot_ff, wc_ff, cs_ff);
                     n = 2'd1;
                  end
                  clr = 1'b1;
                  if (word == 16'hFFFF) begin
                     recs[n[0]] = rec_event_end(ec_ff, fl_ff);
                     n = n + 2'd1;
                     ec_in = ec_ff + 32'd1;
                     fl_in = 2'd3;
                     state_in = ST_WAIT_BOARD;
                  end else if (hi4 == 4'hF) begin
                     s = word[4:0];
                     slot_in = s;
                     if (slot_ok(s)) begin
                        recs[n[0]] = rec_blank(KIND_BOARD_HDR, s);
                        recs[n[0]].value_a = {28'h0, word[8:5]};
                        recs[n[0]].flags = word[11:9];
                        n = n + 2'd1;
                        wc_in = '0;
                        cs_in = '0;
                        state_in = ST_WCNT;
                     end else begin
                        state_in = ST_RESYNC;
                     end
                  end else begin
                     state_in = ST_RESYNC;
                  end
               end
               ST_RESYNC: begin
                  if (word == 16'h0) state_in = ST_EV_END;
                  else if (word == 16'hFFFF) state_in = ST_HDR_L;
               end
               ST_EV_END: begin
                  clr = 1'b1;
                  if (word == end_pat) begin
                     fl_in = fl_ff & 2'd2;
                     state_in = ST_WAIT_START;
                  end else if (word == board_pat) begin
                     fl_in = fl_ff | 2'd1;
                     state_in = ST_HDR_L;
                  end
               end
               default: begin
                  state_in = ST_WAIT_START;
               end
            endcase
         end
      end
   end

   always_comb begin
      cmd.nrec = n;
      cmd.rec0 = recs[0];
      cmd.rec1 = recs[1];
      cmd.clr_sc = clr;
      cmd.sop = sop;
      cmd.sdata = word[14:0];
      cmd.slot = slot_ff;
      cmd.chan_info = ci_ff;
      cmd.region_idx = rc_ff - 16'd1;
      cmd.region_time = rt_ff;
      cmd_push = accept && ((n != 2'd0) || clr || (sop != SOP_NONE));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_WAIT_START; half_ff <= 1'b0; low_ff <= '0; slot_ff <= '0;
         wc_ff <= '0; cs_ff <= '0; ec_ff <= '0; rc_ff <= '0; sm_ff <= '0; em_ff <= '0;
         rt_ff <= '0; armed_ff <= 1'b1; fl_ff <= '0; ci_ff <= '0;
      end else begin
         state_ff <= state_in; half_ff <= half_in; low_ff <= low_in; slot_ff <= slot_in;
         wc_ff <= wc_in; cs_ff <= cs_in; ec_ff <= ec_in; rc_ff <= rc_in; sm_ff <= sm_in;
         em_ff <= em_in; rt_ff <= rt_in; armed_ff <= armed_in; fl_ff <= fl_in;
         ci_ff <= ci_in;
      end
   end
endmodule

@@ design/rsd_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// Deframer command queue
// Four-entry queue of parser commands between the front and the back.
// ----------------------------------------------------------------------------
module rsd_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rsd_pkg::cmd_type  push_data,
   input  logic              pop,
   output rsd_pkg::cmd_type  pop_data,
   output logic              full,
   output logic              not_empty
);
   import rsd_pkg::*;

   cmd_type     mem [4];
   logic [1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [2:0]  cnt_ff, cnt_in;

   always_comb begin
      wr_in = wr_ff + {1'b0, push};
      rd_in = rd_ff + {1'b0, pop};
      cnt_in = cnt_ff + {2'b0, push} - {2'b0, pop};
      full = (cnt_ff == 3'd4);
      not_empty = (cnt_ff != 3'd0);
      pop_data = mem[rd_ff];
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

@@ design/rsd_back.sv @@
// ----------------------------------------------------------------------------
// Deframer record back end
// Expands commands into result records, including zero-run sample words.
// ----------------------------------------------------------------------------
module rsd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic [59:0]       huff_tab,
   input  logic              cmd_avail,
   input  rsd_pkg::cmd_type  cmd_head,
   output logic              cmd_pop,
   rsd_rsp_if.source         rsp_bus
);
   import rsd_pkg::*;

   cmd_type     cur_ff, cur_in;
   logic        busy_ff, busy_in;
   logic        idx_ff, idx_in;
   logic [14:0] mask_ff, mask_in;
   logic [15:0] adc_ff, adc_in, sc_ff, sc_in;
   logic        ov_ff, ov_in;
   rec_type     orec_ff, orec_in;
   logic [15:0] oridx_ff, oridx_in, otime_ff, otime_in, oadc_ff, oadc_in;
   logic        olast_ff, olast_in;

   logic        out_free, emit, done;
   logic [3:0]  lo_pos, hi_pos, run;
   logic [14:0] rest;
   logic [3:0]  dlt;
   logic [15:0] samp;
   logic        new_busy;

   function automatic logic [3:0] low_index(logic [14:0] m);
      logic [3:0] p;
      p = 4'd15;
      for (int i = 14; i >= 0; i--) begin
         if (m[i]) p = 4'(i);
      end
      return p;
   endfunction

   always_comb begin
      cur_in = cur_ff; busy_in = busy_ff; idx_in = idx_ff; mask_in = mask_ff;
      adc_in = adc_ff; sc_in = sc_ff;
      ov_in = ov_ff && !rsp_bus.ready;
      orec_in = orec_ff; oridx_in = oridx_ff; otime_in = otime_ff; oadc_in = oadc_ff;
      olast_in = olast_ff;
      out_free = !ov_ff || rsp_bus.ready;
      emit = 1'b0; done = 1'b0;
      rest = mask_ff & (mask_ff - 15'd1);
      lo_pos = low_index(mask_ff);
      hi_pos = low_index(rest);
      run = hi_pos - lo_pos - 4'd1;
      dlt = huff_tab[{run, 2'b00} +: 4];
      samp = '0;
      new_busy = 1'b0;

      if (busy_ff && out_free) begin
         emit = 1'b1;
         oridx_in = '0; otime_in = '0; oadc_in = '0;
         if (idx_ff == 1'b0 && cur_ff.nrec != 2'd0) begin
            orec_in = cur_ff.rec0;
            done = (cur_ff.nrec == 2'd1);
            idx_in = 1'b1;
         end else if (cur_ff.nrec == 2'd2) begin
            orec_in = cur_ff.rec1;
            done = 1'b1;
         end else begin
            orec_in = rec_blank(KIND_SAMPLE, cur_ff.slot);
            orec_in.chan_num = cur_ff.chan_info[5:0];
            orec_in.chan_frame = cur_ff.chan_info[11:6];
            oridx_in = cur_ff.region_idx;
            otime_in = {2'b00, cur_ff.region_time} + sc_ff;
            unique case (cur_ff.sop)
               SOP_PLAIN: begin
                  samp = {4'h0, cur_ff.sdata[11:0]};
                  adc_in = samp;
                  sc_in = sc_ff + 16'd1;
                  done = 1'b1;
               end
               SOP_LAST: begin
                  samp = {4'h0, cur_ff.sdata[11:0]};
                  done = 1'b1;
               end
               SOP_HUFF: begin
                  samp = adc_ff + {{12{dlt[3]}}, dlt};
                  adc_in = samp;
                  sc_in = sc_ff + 16'd1;
                  mask_in = rest;
                  done = (rest == 15'd0);
               end
               default: begin
                  done = 1'b1;
               end
            endcase
            oadc_in = samp;
         end
         olast_in = done;
         ov_in = 1'b1;
      end

      cmd_pop = cmd_avail && (!busy_ff || done);
      if (done) busy_in = 1'b0;
      if (cmd_pop) begin
         new_busy = (cmd_head.nrec != 2'd0) || (cmd_head.sop == SOP_PLAIN) ||
                    (cmd_head.sop == SOP_LAST) ||
                    (cmd_head.sop == SOP_HUFF && cmd_head.sdata != 15'd0);
         cur_in = cmd_head;
         idx_in = 1'b0;
         mask_in = cmd_head.sdata;
         busy_in = new_busy;
         if (cmd_head.clr_sc) sc_in = '0;
      end
   end

   always_comb begin
      rsp_bus.valid = ov_ff;
      rsp_bus.kind = orec_ff.kind;
      rsp_bus.board_slot = orec_ff.slot;
      rsp_bus.channel_number = orec_ff.chan_num;
      rsp_bus.channel_frame = orec_ff.chan_frame;
      rsp_bus.region_index = oridx_ff;
      rsp_bus.sample_time = otime_ff;
      rsp_bus.adc_value = oadc_ff;
      rsp_bus.value_a = orec_ff.value_a;
      rsp_bus.value_b = orec_ff.value_b;
      rsp_bus.flag_bits = orec_ff.flags;
      rsp_bus.last = olast_ff;
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      idx_ff <= idx_in;
      mask_ff <= mask_in;
      if (emit) begin
         orec_ff <= orec_in;
         oridx_ff <= oridx_in;
         otime_ff <= otime_in;
         oadc_ff <= oadc_in;
         olast_ff <= olast_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         ov_ff <= 1'b0;
         adc_ff <= '0;
         sc_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         ov_ff <= ov_in;
         adc_ff <= adc_in;
         sc_ff <= sc_in;
      end
   end
endmodule
